// ===== sv/koc_pkg.sv =====
// shared types, constants and character class helpers for the keyword occurrence counter
package koc_pkg;

  localparam int unsigned RegKeys  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned CountW   = 32;
  localparam int unsigned KeyIdxOW = 3;
  localparam int unsigned LenW     = 7;

  localparam logic [CountW-1:0] CountMax = '1;

  // reset keywords: auto, char, return, void, while (first char in low byte)
  localparam logic [RegKeys-1:0][KeyW-1:0] KeyReset = {
    64'h0000_0065_6C69_6877,
    64'h0000_0000_6469_6F76,
    64'h0000_6E72_7574_6572,
    64'h0000_0000_7261_6863,
    64'h0000_0000_6F74_7561
  };

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [KeyIdxOW-1:0] key_index;
    logic [CountW-1:0]   occurrences;
    logic                last_of_dump;
  } out_item_t;

  typedef enum logic [1:0] {
    DumpIdle,
    DumpWait,
    DumpEmit
  } dump_state_e;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = is_letter(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

// ===== sv/keyword_occurrence_counter_unit.sv =====
// keyword occurrence counter: tokeniser, parallel keyword match and count dump
// a word closed by a text byte is held in the finished word register, then lands in its count
// throughput: one byte per cycle outside a dump, set by the single-pass word register update
// end of text: ready drops for the settle state and each active key's emit (plus stalls)
// first count is offered at the output after the settle state, once the emit state loads it
// reset: counts, word state and handshakes clear at once; keywords return to their defaults
module keyword_occurrence_counter_unit #(
  parameter int unsigned NUM_KEYS   = 5,
  parameter int unsigned WORD_LIMIT = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // text input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  koc_pkg::in_item_t             in_data_i,
  // count output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output koc_pkg::out_item_t            out_data_o,
  // keyword write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [koc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [koc_pkg::KeyW-1:0]      cfg_data_i
);

  // only the first keywords up to the register count take part
  localparam int unsigned ActiveKeys = (NUM_KEYS < koc_pkg::RegKeys) ? NUM_KEYS
                                                                    : koc_pkg::RegKeys;
  localparam int unsigned KeyIdxW    = (ActiveKeys > 1) ? $clog2(ActiveKeys) : 1;
  localparam logic [KeyIdxW-1:0] LastKey = KeyIdxW'(ActiveKeys - 1);
  localparam logic [koc_pkg::LenW-1:0] WordLimit = koc_pkg::LenW'(WORD_LIMIT);

  // keyword registers
  logic [ActiveKeys-1:0][koc_pkg::KeyW-1:0] keys_q;

  // open word state
  logic [koc_pkg::KeyW-1:0]  word_head_q, word_head_d;
  logic [koc_pkg::LenW-1:0]  word_len_q, word_len_d;
  logic                      swl_q, swl_d;

  // finished word waiting for its compare
  logic                      fin_valid_q, fin_valid_d;
  logic [koc_pkg::KeyW-1:0]  fin_head_q;
  logic [3:0]                fin_len_q;

  // counts and dump sequencer
  logic [ActiveKeys-1:0][koc_pkg::CountW-1:0] counts_q, counts_d;
  koc_pkg::dump_state_e      state_q, state_d;
  logic [KeyIdxW-1:0]        idx_q, idx_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  koc_pkg::out_item_t        out_data_q;
  logic                      out_load;

  logic                      in_fire;
  logic [7:0]                in_byte;

  // match logic
  logic [7:0]                lane_en;
  logic [koc_pkg::KeyW-1:0]  len_mask;
  logic [ActiveKeys-1:0]     key_eq;
  logic [ActiveKeys-1:0]     hit_oh;
  logic                      hit_seen;

  assign in_ready_o  = (state_q == koc_pkg::DumpIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_byte     = in_data_i.text_byte;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // keyword writes, indexes beyond the active set are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ActiveKeys; k++) begin
        keys_q[k] <= koc_pkg::KeyReset[k];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int k = 0; k < ActiveKeys; k++) begin
        if (cfg_index_i == koc_pkg::CfgIdxW'(k)) begin
          keys_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // tokeniser: grow the open word or close it
  always_comb begin
    word_head_d = word_head_q;
    word_len_d  = word_len_q;
    swl_d       = swl_q;
    fin_valid_d = 1'b0;
    if (in_fire) begin
      if (!in_data_i.action && koc_pkg::is_alnum(in_byte)) begin
        if (word_len_q == '0) begin
          swl_d = koc_pkg::is_letter(in_byte);
        end
        if (word_len_q < koc_pkg::LenW'(8)) begin
          word_head_d[{word_len_q[2:0], 3'b000} +: 8] = in_byte;
        end
        word_len_d = word_len_q + koc_pkg::LenW'(1);
        // word cut at the limit, too long to ever match
        if (word_len_d >= WordLimit) begin
          word_head_d = '0;
          word_len_d  = '0;
          swl_d       = 1'b0;
        end
      end else begin
        // separator, single-char token or end of text closes the word
        fin_valid_d = (word_len_q != '0) && swl_q && (word_len_q <= koc_pkg::LenW'(8));
        word_head_d = '0;
        word_len_d  = '0;
        swl_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_head_q <= '0;
      word_len_q  <= '0;
      swl_q       <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      word_head_q <= word_head_d;
      word_len_q  <= word_len_d;
      swl_q       <= swl_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  // finished word payload, only used when fin_valid_q is set
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fin_head_q <= word_head_q;
      fin_len_q  <= word_len_q[3:0];
    end
  end

  // parallel compare: head bytes are non-zero, so equal masked bytes plus a
  // zero terminator in the key at the word length means equal lengths
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      lane_en[l]             = (4'(l) < fin_len_q);
      len_mask[l*8 +: 8]     = {8{lane_en[l]}};
    end
    for (int k = 0; k < ActiveKeys; k++) begin
      key_eq[k] = ((keys_q[k] & len_mask) == fin_head_q)
               && ((fin_len_q == 4'd8)
                   || (keys_q[k][{fin_len_q[2:0], 3'b000} +: 8] == 8'h00));
    end
    // lowest matching keyword wins
    hit_seen = 1'b0;
    hit_oh   = '0;
    for (int k = 0; k < ActiveKeys; k++) begin
      if (key_eq[k] && !hit_seen) begin
        hit_oh[k] = 1'b1;
        hit_seen  = 1'b1;
      end
    end
  end

  // dump sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    case (state_q)
      koc_pkg::DumpIdle: begin
        if (in_fire && in_data_i.action) begin
          state_d = koc_pkg::DumpWait;
        end
      end
      // lets the word closed by the end of text reach its count
      koc_pkg::DumpWait: begin
        state_d = koc_pkg::DumpEmit;
        idx_d   = '0;
      end
      koc_pkg::DumpEmit: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) begin
          if (idx_q == LastKey) begin
            state_d = koc_pkg::DumpIdle;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + KeyIdxW'(1);
          end
        end
      end
      default: begin
        state_d = koc_pkg::DumpIdle;
        idx_d   = '0;
      end
    endcase
  end

  // saturating count update and clear on emit
  always_comb begin
    counts_d = counts_q;
    for (int k = 0; k < ActiveKeys; k++) begin
      if (fin_valid_q && hit_oh[k] && (counts_q[k] != koc_pkg::CountMax)) begin
        counts_d[k] = counts_q[k] + koc_pkg::CountW'(1);
      end
      if (out_load && (idx_q == KeyIdxW'(k))) begin
        counts_d[k] = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= koc_pkg::DumpIdle;
      idx_q       <= '0;
      counts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      counts_q    <= counts_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.key_index    <= koc_pkg::KeyIdxOW'(idx_q);
      out_data_q.occurrences  <= counts_q[idx_q];
      out_data_q.last_of_dump <= (idx_q == LastKey);
    end
  end

`ifndef ASSERT_OFF
  // an end-of-text transfer blocks further input at least through the settle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action) |=> !in_ready_o)
    else $error("input still ready after end of text");

  // a pending word compare must land before counts are emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> (state_q != koc_pkg::DumpEmit))
    else $error("count emitted while a word compare is pending");

  // the dump marker sits on the last active keyword only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.last_of_dump
                     == (out_data_q.key_index == koc_pkg::KeyIdxOW'(ActiveKeys - 1))))
    else $error("last_of_dump on wrong keyword");

  // a new result only appears out of the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == koc_pkg::DumpEmit))
    else $error("result offered outside a dump");
`endif

endmodule

// ===== dv/keyword_occurrence_counter_unit_tb.sv =====
// self-checking testbench for the keyword occurrence counter unit
module keyword_occurrence_counter_unit_tb;

  localparam int unsigned NumKeys     = 5;
  localparam int unsigned WordLimit   = 100;
  localparam int unsigned ActiveKeys  = (NumKeys < koc_pkg::RegKeys) ? NumKeys
                                                                     : koc_pkg::RegKeys;
  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HeadBytes   = 8;

  // input action codes
  localparam logic ActText = 1'b0;
  localparam logic ActEnd  = 1'b1;

  // keyword register indexes
  localparam logic [koc_pkg::CfgIdxW-1:0] RegKey0 = koc_pkg::CfgIdxW'(0);
  localparam logic [koc_pkg::CfgIdxW-1:0] RegKey1 = koc_pkg::CfgIdxW'(1);
  localparam logic [koc_pkg::CfgIdxW-1:0] RegKey2 = koc_pkg::CfgIdxW'(2);
  localparam logic [koc_pkg::CfgIdxW-1:0] RegKey3 = koc_pkg::CfgIdxW'(3);
  localparam logic [koc_pkg::CfgIdxW-1:0] RegKey4 = koc_pkg::CfgIdxW'(4);

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  koc_pkg::in_item_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  koc_pkg::out_item_t           out_data_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [koc_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [koc_pkg::KeyW-1:0]     cfg_data_i  = '0;

  // idling percentages for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // tokeniser and tally mirror
  logic [koc_pkg::KeyW-1:0]   kw_table [koc_pkg::RegKeys];
  logic [koc_pkg::KeyW-1:0]   open_word_head;
  logic [koc_pkg::LenW-1:0]   open_word_len;
  logic                       open_word_alpha;
  logic [koc_pkg::CountW-1:0] tally [koc_pkg::RegKeys];

  // dump counts still owed by the block, oldest first
  koc_pkg::out_item_t pending_counts[$];
  koc_pkg::out_item_t wanted_count;

  keyword_occurrence_counter_unit #(
    .NUM_KEYS   (NumKeys),
    .WORD_LIMIT (WordLimit)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic char_is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic char_is_alnum(input logic [7:0] c);
    return char_is_letter(c) || (c inside {[8'h30:8'h39]});
  endfunction

  // keyword ends at its first zero byte
  function automatic int key_length(input logic [koc_pkg::KeyW-1:0] k);
    int n;
    n = 0;
    while (n < HeadBytes && k[8*n +: 8] != 8'h00) n++;
    return n;
  endfunction

  // ends the open word; a letter-led word of up to eight characters is looked up
  function automatic void close_open_word();
    int n;
    logic [koc_pkg::KeyW-1:0] mask;
    if (open_word_len != 0 && open_word_alpha && open_word_len <= HeadBytes) begin
      for (int i = 0; i < ActiveKeys; i++) begin
        n = key_length(kw_table[i]);
        mask = (n >= HeadBytes) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        // the lowest matching keyword takes the hit, duplicates above it never count
        if (n == open_word_len && (kw_table[i] & mask) == open_word_head) begin
          if (tally[i] != koc_pkg::CountMax) tally[i]++;
          break;
        end
      end
    end
    open_word_head  = '0;
    open_word_len   = '0;
    open_word_alpha = 1'b0;
  endfunction

  function automatic void advance_tally(input koc_pkg::in_item_t item);
    koc_pkg::out_item_t res;
    if (item.action == ActEnd) begin
      close_open_word();
      for (int i = 0; i < ActiveKeys; i++) begin
        res.key_index    = koc_pkg::KeyIdxOW'(i);
        res.occurrences  = tally[i];
        res.last_of_dump = (i == ActiveKeys - 1);
        pending_counts.push_back(res);
        tally[i] = '0;
      end
    end else if (char_is_alnum(item.text_byte)) begin
      if (open_word_len == 0) open_word_alpha = char_is_letter(item.text_byte);
      if (open_word_len < HeadBytes) open_word_head[8*open_word_len +: 8] = item.text_byte;
      open_word_len++;
      // over-long word is cut here, the next character opens a fresh one
      if (open_word_len >= WordLimit) close_open_word();
    end else begin
      close_open_word();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one text channel transfer; valid is left high so a following item can go back to back
  task automatic send_item(input logic act, input logic [7:0] ch);
    koc_pkg::in_item_t item;
    item.action    = act;
    item.text_byte = ch;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    advance_tally(item);
  endtask

  task automatic send_dump();
    send_item(ActEnd, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ActText, s[i]);
  endtask

  task automatic send_run(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) send_item(ActText, c);
  endtask

  // keyword write, only ever issued while the block is idle
  task automatic write_key(input logic [koc_pkg::CfgIdxW-1:0] idx,
                           input logic [koc_pkg::KeyW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < koc_pkg::RegKeys) kw_table[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drop the text channel and wait until every owed count has gone out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [koc_pkg::KeyW-1:0] pack_word(input string s);
    logic [koc_pkg::KeyW-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < HeadBytes; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  function automatic logic [7:0] pick_alnum(input bit letter_only);
    int unsigned r;
    r = letter_only ? $urandom_range(51) : $urandom_range(61);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    return 8'h30 + 8'(r - 52);
  endfunction

  // white space half the time, otherwise any byte that cannot be part of a word
  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(5))
        0:       c = 8'h20;
        1:       c = 8'h09;
        2:       c = 8'h0A;
        3:       c = 8'h0B;
        4:       c = 8'h0C;
        default: c = 8'h0D;
      endcase
    end else begin
      c = 8'($urandom_range(255));
      while (char_is_alnum(c)) c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: count transfer with none expected, actual key %0d count %0d last %0d",
                 $time, out_data_o.key_index, out_data_o.occurrences, out_data_o.last_of_dump);
        fail_count++;
      end else begin
        wanted_count = pending_counts.pop_front();
        if (out_data_o.key_index !== wanted_count.key_index) begin
          $display("%0t: key_index expected %0d actual %0d",
                   $time, wanted_count.key_index, out_data_o.key_index);
          fail_count++;
        end
        if (out_data_o.occurrences !== wanted_count.occurrences) begin
          $display("%0t: occurrences of key %0d expected %0d actual %0d", $time,
                   wanted_count.key_index, wanted_count.occurrences, out_data_o.occurrences);
          fail_count++;
        end
        if (out_data_o.last_of_dump !== wanted_count.last_of_dump) begin
          $display("%0t: last_of_dump of key %0d expected %0d actual %0d", $time,
                   wanted_count.key_index, wanted_count.last_of_dump, out_data_o.last_of_dump);
          fail_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // dumps straight after reset and back to back report all zero
  task automatic test_empty_dump();
    set_idling(0, 0);
    send_dump();
    send_dump();
    settle();
  endtask

  // reset keywords, odd separators, case and digit-led words
  task automatic test_default_keywords();
    set_idling(0, 0);
    send_text("auto");
    send_item(ActText, 8'h00);
    send_text("9void");
    send_item(ActText, 8'hFF);
    send_text("Auto");
    send_item(ActText, 8'h0A);
    send_text("while");
    // open word closed by the dump itself, whose byte is alphanumeric and ignored
    send_item(ActEnd, 8'h61);
    settle();
  endtask

  // full-width, empty, zero-terminated and duplicate keywords
  task automatic test_key_packing();
    set_idling(0, 0);
    write_key(RegKey0, pack_word("abcdefgh"));
    write_key(RegKey1, '0);
    write_key(RegKey2, 64'h0000_7A79_7800_6261);   // "ab", bytes past the terminator ignored
    write_key(RegKey3, pack_word("dup"));
    write_key(RegKey4, pack_word("dup"));
    // indexes past the last keyword are dropped
    write_key(koc_pkg::CfgIdxW'(koc_pkg::RegKeys), {$urandom, $urandom});
    write_key('1, {$urandom, $urandom});
    send_text("abcdefgh abcdefghi ab dup,dup");
    send_dump();
    settle();
  endtask

  // a word cut at the length limit, the remainder starting a word of its own
  task automatic test_long_words();
    set_idling(0, 0);
    for (int i = 0; i < koc_pkg::RegKeys; i++) begin
      write_key(koc_pkg::CfgIdxW'(i), koc_pkg::KeyReset[i]);
    end
    send_run("x", WordLimit);
    send_text("char");
    send_dump();
    settle();
  endtask

  // mostly short alphanumeric keywords that real text can hit, some raw values and repeats
  task automatic load_keys_random(input bit extremes);
    logic [koc_pkg::KeyW-1:0] k;
    int n;
    for (int i = 0; i < koc_pkg::RegKeys; i++) begin
      if (extremes && i == 0) begin
        k = '1;
      end else if (extremes && i == 1) begin
        k = '0;
      end else if ($urandom_range(4) == 0) begin
        k = {$urandom, $urandom};
      end else if (i != 0 && $urandom_range(5) == 0) begin
        k = kw_table[i-1];
      end else begin
        k = '0;
        n = $urandom_range(1, HeadBytes);
        for (int j = 0; j < n; j++) k[8*j +: 8] = pick_alnum(j == 0);
      end
      write_key(koc_pkg::CfgIdxW'(i), k);
    end
  endtask

  // keyword-heavy text with near misses, random words, noise and the odd dump
  task automatic random_text(input int n_items);
    int sent;
    int sel;
    int pos;
    logic [koc_pkg::KeyW-1:0] key;
    logic [7:0] word_q[$];
    sent = 0;
    while (sent < n_items) begin
      word_q.delete();
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_dump();
        sent++;
      end else begin
        if (sel < 70) begin
          key = kw_table[$urandom_range(ActiveKeys - 1)];
          for (int j = 0; j < key_length(key); j++) word_q.push_back(key[8*j +: 8]);
          // near miss: flipped case or a replaced digit, one character too many or too few
          if (sel >= 55 && word_q.size() != 0) begin
            pos = $urandom_range(word_q.size() - 1);
            case ($urandom_range(2))
              0: word_q[pos] = char_is_letter(word_q[pos]) ? (word_q[pos] ^ 8'h20)
                                                            : pick_alnum(1'b0);
              1: word_q.push_back(pick_alnum(1'b0));
              default: void'(word_q.pop_back());
            endcase
          end
        end else if (sel < 85) begin
          repeat ($urandom_range(1, 10)) word_q.push_back(pick_alnum(1'b0));
        end else begin
          repeat ($urandom_range(1, 3)) word_q.push_back(8'($urandom_range(255)));
        end
        // words occasionally run together
        if ($urandom_range(9) != 0) word_q.push_back(pick_separator());
        foreach (word_q[j]) begin
          send_item(ActText, word_q[j]);
          sent++;
        end
      end
    end
    send_dump();
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    load_keys_random(1'b0);
    random_text(5);
    settle();

    set_idling(70, 0);
    load_keys_random(1'b1);
    random_text(5);
    settle();

    set_idling(0, 70);
    load_keys_random(1'b0);
    random_text(5);
    settle();

    set_idling(21, 21);
    load_keys_random(1'b0);
    random_text(5);
    settle();
  endtask

  initial begin
    for (int i = 0; i < koc_pkg::RegKeys; i++) begin
      kw_table[i] = koc_pkg::KeyReset[i];
      tally[i]    = '0;
    end
    open_word_head  = '0;
    open_word_len   = '0;
    open_word_alpha = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_dump();
    test_default_keywords();
    test_key_packing();
    test_long_words();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/koc_pkg.sv
sv/keyword_occurrence_counter_unit.sv
dv/keyword_occurrence_counter_unit_tb.sv
